FILE: sv/deps_pkg.sv
// Shared types and constants for the dual encoder period and speed block.
// Used by deps_mul, deps_div and dual_encoder_period_speed.
`default_nettype none
package deps_pkg;
    // configuration register indexes
    localparam logic [2:0] REG_TICK_RATE = 3'd0;
    localparam logic [2:0] REG_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_DIAMETER  = 3'd2;
    localparam logic [2:0] REG_PPR       = 3'd3;
    localparam logic [2:0] REG_BASE      = 3'd4;

    // operation codes
    localparam logic [1:0] OP_LEFT  = 2'd0;
    localparam logic [1:0] OP_RIGHT = 2'd1;

    // operand and result widths of the serial units
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = 80;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    // pi in Q30
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam logic [39:0] SPEED_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [47:0] YAW_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] YAW_NEG_MAG = 48'h8000_0000_0000;

    // start request to a serial unit
    typedef struct packed {
        logic       start;
        logic [6:0] steps;
    } unit_ctl_t;
endpackage
`default_nettype wire

FILE: sv/deps_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
// Depends on deps_pkg.
`default_nettype none
module deps_mul (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire deps_pkg::unit_ctl_t          ctl,
    input  wire logic [deps_pkg::MUL_A_W-1:0] a,
    input  wire logic [deps_pkg::MUL_B_W-1:0] b,
    output logic                              done,
    output logic [deps_pkg::MUL_P_W-1:0]      product
);
    logic [deps_pkg::MUL_P_W-1:0] acc_reg, ash_reg;
    logic [deps_pkg::MUL_B_W-1:0] b_reg;
    logic [6:0]                   cnt_reg;
    logic                         busy_reg, done_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: add shifted multiplicand when the low multiplier bit is set
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            acc_reg <= '0;
            ash_reg <= {{(deps_pkg::MUL_P_W-deps_pkg::MUL_A_W){1'b0}}, a};
            b_reg   <= b;
        end else if (busy_reg) begin
            if (b_reg[0]) acc_reg <= acc_reg + ash_reg;
            ash_reg <= {ash_reg[deps_pkg::MUL_P_W-2:0], 1'b0};
            b_reg   <= {1'b0, b_reg[deps_pkg::MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

FILE: sv/deps_div.sv
// Restoring divider: one quotient bit per cycle, dividend given MSB-aligned.
// Depends on deps_pkg.
`default_nettype none
module deps_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire deps_pkg::unit_ctl_t          ctl,
    input  wire logic [deps_pkg::DIV_N_W-1:0] dividend,
    input  wire logic [deps_pkg::DIV_D_W-1:0] divisor,
    output logic                              done,
    output logic [deps_pkg::DIV_N_W-1:0]      quotient
);
    logic [deps_pkg::DIV_N_W-1:0] dvd_reg, quo_reg;
    logic [deps_pkg::DIV_D_W-1:0] dsr_reg, rem_reg;
    logic [deps_pkg::DIV_D_W:0]   trial;
    logic                         fits;
    logic [6:0]                   cnt_reg;
    logic                         busy_reg, done_reg;

    assign trial = {rem_reg, dvd_reg[deps_pkg::DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[deps_pkg::DIV_N_W-2:0], 1'b0};
            rem_reg <= fits ? 32'(trial - {1'b0, dsr_reg}) : trial[deps_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[deps_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: sv/dual_encoder_period_speed.sv
// Dual encoder period measurement with wheel speed and yaw-rate output.
// A capture with a nonzero period adds a 35-step frequency division on the shared
// bit-serial divider; the shared multiplier (10 or 32 steps) and divider (47 or 50
// steps) compute the wheel speeds and yaw rate. Input is taken only when idle, after
// the previous transaction; the result register lets the next input be taken while
// a result waits. Reset clears the captures, timestamps and frequencies only.
// Depends on deps_pkg, deps_mul, deps_div.
`default_nettype none
module dual_encoder_period_speed (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wen,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [26:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // capture_value[31:0], now_ms[63:32]
    input  wire logic [1:0]   s_tuser,   // operation[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // left_freq_q8[34:0], right_freq_q8[69:35], left_speed_q8[109:70],
    // right_speed_q8[149:110], forward_speed_q8[189:150], yaw_rate_q8[237:190]
    output logic [239:0]      m_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CAP  = 4'd1;
    localparam logic [3:0] S_EVAL = 4'd2;
    localparam logic [3:0] S_WM1  = 4'd3;
    localparam logic [3:0] S_WM2  = 4'd4;
    localparam logic [3:0] S_WD   = 4'd5;
    localparam logic [3:0] S_YST  = 4'd6;
    localparam logic [3:0] S_YM   = 4'd7;
    localparam logic [3:0] S_YD   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // configuration
    logic [26:0] tick_reg;
    logic [15:0] tmo_reg, ppr_reg;
    logic [9:0]  dia_reg;
    logic [10:0] base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= 27'd1000000;
            tmo_reg  <= 16'd200;
            dia_reg  <= 10'd65;
            ppr_reg  <= 16'd1320;
            base_reg <= 11'd160;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                deps_pkg::REG_TICK_RATE: tick_reg <= cfg_wdata;
                deps_pkg::REG_TIMEOUT:   tmo_reg  <= cfg_wdata[15:0];
                deps_pkg::REG_DIAMETER:  dia_reg  <= cfg_wdata[9:0];
                deps_pkg::REG_PPR:       ppr_reg  <= cfg_wdata[15:0];
                deps_pkg::REG_BASE:      base_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    logic [3:0]  state_reg;
    logic        side_reg, wheel_reg;
    logic [31:0] now_reg;
    logic [31:0] lcap_reg, rcap_reg, lms_reg, rms_reg;
    logic [34:0] lf_reg, rf_reg, fl_reg, fr_reg;
    logic [39:0] vl_reg, vr_reg;
    logic [47:0] yaw_reg;
    logic        yneg_reg;

    deps_pkg::unit_ctl_t          mul_ctl, div_ctl;
    logic [deps_pkg::MUL_A_W-1:0] mul_a;
    logic [deps_pkg::MUL_B_W-1:0] mul_b;
    logic [deps_pkg::MUL_P_W-1:0] prod;
    logic [deps_pkg::DIV_N_W-1:0] dvd, quo;
    logic [deps_pkg::DIV_D_W-1:0] dsr;
    logic                         mul_done, div_done;

    deps_mul u_mul (.aclk, .aresetn, .ctl(mul_ctl), .a(mul_a), .b(mul_b),
                    .done(mul_done), .product(prod));
    deps_div u_div (.aclk, .aresetn, .ctl(div_ctl), .dividend(dvd), .divisor(dsr),
                    .done(div_done), .quotient(quo));

    logic [31:0] in_cap, in_now, period;
    logic        acc_in;
    assign in_cap   = s_tdata[31:0];
    assign in_now   = s_tdata[63:32];
    assign s_tready = (state_reg == S_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign period   = in_cap - ((s_tuser == deps_pkg::OP_RIGHT) ? rcap_reg : lcap_reg);

    // reported frequencies, zero once timed out
    logic [31:0] lage, rage;
    logic [34:0] fl_c, fr_c;
    assign lage = now_reg - lms_reg;
    assign rage = now_reg - rms_reg;
    assign fl_c = (lage > {16'd0, tmo_reg}) ? 35'd0 : lf_reg;
    assign fr_c = (rage > {16'd0, tmo_reg}) ? 35'd0 : rf_reg;

    // wheel speed from the speed quotient
    logic [39:0] spd_c, vl_use;
    logic [39:0] diff_c;
    logic [50:0] ym;
    assign spd_c  = (ppr_reg == 16'd0) ? 40'd0 :
                    (quo[46:40] != 7'd0) ? deps_pkg::SPEED_MAX : quo[39:0];
    assign vl_use = vl_reg;
    assign diff_c = (vr_reg >= vl_use) ? vr_reg - vl_use : vl_use - vr_reg;
    assign ym     = quo[50:0];

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lcap_reg  <= '0;
            rcap_reg  <= '0;
            lms_reg   <= '0;
            rms_reg   <= '0;
            lf_reg    <= '0;
            rf_reg    <= '0;
            side_reg  <= 1'b0;
            wheel_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (acc_in) begin
                    now_reg  <= in_now;
                    side_reg <= (s_tuser == deps_pkg::OP_RIGHT);
                    state_reg <= S_EVAL;
                    if (s_tuser == deps_pkg::OP_LEFT) begin
                        lcap_reg <= in_cap;
                        lms_reg  <= in_now;
                    end
                    if (s_tuser == deps_pkg::OP_RIGHT) begin
                        rcap_reg <= in_cap;
                        rms_reg  <= in_now;
                    end
                    if ((s_tuser == deps_pkg::OP_LEFT || s_tuser == deps_pkg::OP_RIGHT)
                        && period != 32'd0)
                        state_reg <= S_CAP;
                end
                S_CAP: if (div_done) begin
                    if (side_reg) rf_reg <= quo[34:0];
                    else          lf_reg <= quo[34:0];
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    fl_reg    <= fl_c;
                    fr_reg    <= fr_c;
                    wheel_reg <= 1'b0;
                    state_reg <= S_WM1;
                end
                S_WM1: if (mul_done) state_reg <= S_WM2;
                S_WM2: if (mul_done) state_reg <= S_WD;
                S_WD: if (div_done) begin
                    if (wheel_reg) begin
                        vr_reg    <= spd_c;
                        state_reg <= S_YST;
                    end else begin
                        vl_reg    <= spd_c;
                        wheel_reg <= 1'b1;
                        state_reg <= S_WM1;
                    end
                end
                S_YST: begin
                    yneg_reg  <= (vr_reg < vl_reg);
                    state_reg <= S_YM;
                end
                S_YM: if (mul_done) state_reg <= S_YD;
                S_YD: if (div_done) begin
                    if (base_reg == 11'd0)
                        yaw_reg <= '0;
                    else if (!yneg_reg)
                        yaw_reg <= (ym > {3'd0, deps_pkg::YAW_POS_MAX}) ?
                                   deps_pkg::YAW_POS_MAX : ym[47:0];
                    else
                        yaw_reg <= (ym > {3'd0, deps_pkg::YAW_NEG_MAG}) ?
                                   deps_pkg::YAW_NEG_MAG : 48'(48'd0 - ym[47:0]);
                    state_reg <= S_OUT;
                end
                S_OUT: if (!m_tvalid || m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // unit starts, issued on the edge that enters each compute state
    logic        load_w;
    assign load_w = (state_reg == S_EVAL) || (state_reg == S_WD && div_done && !wheel_reg);

    always_comb begin
        mul_ctl = '0;
        div_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        dvd     = '0;
        dsr     = '0;
        if (acc_in) begin
            div_ctl.start = 1'b1;
            div_ctl.steps = 7'd35;
            dvd = {tick_reg, 8'd0, 29'd0};
            dsr = period;
        end
        if (load_w) begin
            mul_ctl.start = 1'b1;
            mul_ctl.steps = 7'd10;
            mul_a = {13'd0, (state_reg == S_EVAL) ? fl_c : fr_reg};
            mul_b = {22'd0, dia_reg};
        end
        if (state_reg == S_WM1 && mul_done) begin
            mul_ctl.start = 1'b1;
            mul_ctl.steps = 7'd32;
            mul_a = {3'd0, prod[44:0]};
            mul_b = deps_pkg::PI_Q30;
        end
        if (state_reg == S_WM2 && mul_done) begin
            div_ctl.start = 1'b1;
            div_ctl.steps = 7'd47;
            dvd = {prod[76:30], 17'd0};
            dsr = {16'd0, ppr_reg};
        end
        if (state_reg == S_YST) begin
            mul_ctl.start = 1'b1;
            mul_ctl.steps = 7'd10;
            mul_a = {8'd0, diff_c};
            mul_b = 32'd1000;
        end
        if (state_reg == S_YM && mul_done) begin
            div_ctl.start = 1'b1;
            div_ctl.steps = 7'd50;
            dvd = {prod[49:0], 14'd0};
            dsr = {21'd0, base_reg};
        end
    end

    // result register
    logic        out_load;
    logic [40:0] fsum;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid || m_tready);
    assign fsum     = {1'b0, vl_reg} + {1'b0, vr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= {2'b00, yaw_reg, fsum[40:1], vr_reg, vl_reg, fr_reg, fl_reg};
        end
    end

    // the two serial units are never started together
    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_ctl.start && div_ctl.start))
        else $error("multiplier and divider started together");
    // a new result appears only from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result valid without output state");
    // a capture division runs only after a capture transaction
    a_cap_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CAP && $past(state_reg == S_IDLE)) |-> $past(acc_in))
        else $error("capture division without input");
    // input is refused during the wheel division
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WD) |-> !s_tready)
        else $error("input ready during wheel division");
endmodule
`default_nettype wire
